// File: hdl/pfl_pkg.sv
// Package with the shared codes, types and reset constants of the PWM fan level controller.
package pfl_pkg;

    localparam int NUM_LEVELS = 8;

    typedef logic [2:0] t_opcode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cfg_index;
    typedef logic [1:0] t_mode;

    localparam t_opcode OP_WR_LEVEL    = 3'd0;
    localparam t_opcode OP_WR_MODE     = 3'd1;
    localparam t_opcode OP_SET_STATE   = 3'd2;
    localparam t_opcode OP_RD_LEVEL    = 3'd3;
    localparam t_opcode OP_RD_MODE     = 3'd4;
    localparam t_opcode OP_RD_STATE    = 3'd5;
    localparam t_opcode OP_RD_TOP      = 3'd6;
    localparam t_opcode OP_UNSUPPORTED = 3'd7;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_INVALID     = 2'd1;
    localparam t_status ST_UNSUPPORTED = 2'd2;

    localparam t_cfg_index CFG_PWM_PERIOD     = 2'd0;
    localparam t_cfg_index CFG_COOLING_LEVELS = 2'd1;
    localparam t_cfg_index CFG_TOP_STATE      = 2'd2;
    localparam t_cfg_index CFG_HAS_REGULATOR  = 2'd3;

    localparam t_mode MODE_DISABLED  = 2'd0;
    localparam t_mode MODE_SUPPLY_ON = 2'd1;
    localparam t_mode MODE_OUTPUT_ON = 2'd2;
    localparam t_mode MODE_AUTO      = 2'd3;

    localparam logic [7:0]  MAX_LEVEL = 8'd255;
    localparam logic [2:0]  MAX_STATE = 3'(NUM_LEVELS - 1);

    localparam logic [15:0] RST_PWM_PERIOD     = 16'd10000;
    localparam logic [63:0] RST_COOLING_LEVELS = 64'hFFFF_FFFF_E6AA_6600;
    localparam logic [2:0]  RST_TOP_STATE      = 3'd4;
    localparam logic        RST_HAS_REGULATOR  = 1'b1;
    localparam logic [7:0]  RST_LEVEL          = MAX_LEVEL;
    localparam t_mode       RST_MODE           = MODE_SUPPLY_ON;
    localparam logic [15:0] RST_DUTY           = RST_PWM_PERIOD - 16'd1;
    localparam logic [2:0]  RST_STATE          =
        (RST_TOP_STATE > MAX_STATE) ? MAX_STATE : RST_TOP_STATE;

endpackage

// File: hdl/pfl_if.sv
// Channel interfaces for the request and result beats of the PWM fan level controller.
interface pfl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface pfl_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] duty_count;
    logic        pwm_output_on;
    logic        supply_on;
    logic [2:0]  cooling_state;
    logic [1:0]  status;

    modport source (output valid, output read_data, output duty_count, output pwm_output_on,
                    output supply_on, output cooling_state, output status, input ready);
    modport sink (input valid, input read_data, input duty_count, input pwm_output_on,
                  input supply_on, input cooling_state, input status, output ready);
endinterface

// File: hdl/pwm_fan_level_controller_top.sv
// Top level of the PWM fan level controller: request decode, fan state and result register.
// Each request beat is accepted and its result appears in the output register on
// the next cycle; a new beat can be taken every cycle while the result register is empty or its
// beat is taken in the same cycle, so a stalled result holds off the request channel.
// The rate is set by the combinational path from the request through the level-times-period
// multiplier and the add-based divide by 255 into the state and result registers.
module pwm_fan_level_controller_top
    import pfl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_cfg_index    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    pfl_in_if.sink        i_in,
    pfl_out_if.source     o_out
);

    logic [15:0] r_period;
    logic [63:0] r_levels;
    logic [2:0]  r_top;
    logic        r_has_reg;

    logic [7:0]  r_level, n_level;
    t_mode       r_mode, n_mode;
    logic        r_running, n_running;
    logic        r_out_en, n_out_en;
    logic        r_supply, n_supply;
    logic [15:0] r_duty, n_duty;
    logic [2:0]  r_state, n_state;

    logic        r_out_valid;
    logic [7:0]  r_rd_data, n_rd_data;
    t_status     r_status, n_status;

    logic        in_fire;
    t_opcode     op;
    logic [15:0] val;
    logic [2:0]  eff_top;
    logic [15:0] period_less_one;
    logic [7:0]  apply_lv;
    logic [7:0]  track_lv;
    logic [2:0]  track_state;
    logic        do_apply;

    logic [23:0] prod;
    logic [23:0] dividend;
    logic [24:0] sum_est;
    logic [16:0] quot_est;
    logic [24:0] rem_est;
    logic [16:0] quot;
    logic [15:0] duty_calc;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign op = i_in.opcode;
    assign val = i_in.value;

    assign eff_top = (r_top > MAX_STATE) ? MAX_STATE : r_top;
    assign period_less_one = (r_period == 16'd0) ? 16'd0 : r_period - 16'd1;

    assign apply_lv = (op == OP_SET_STATE) ? r_levels[val[2:0] * 8 +: 8] : val[7:0];
    assign track_lv = (op == OP_WR_LEVEL) ? val[7:0] : 8'd0;

    // Rounded-up duty: (lv * (period - 1) + 254) / 255, with the divide done by a
    // geometric-series estimate that is at most one low, then one correction step.
    assign prod      = 24'(apply_lv) * 24'(period_less_one);
    assign dividend  = prod + 24'd254;
    assign sum_est   = 25'(dividend) + 25'(dividend >> 8) + 25'(dividend >> 16);
    assign quot_est  = sum_est[24:8];
    assign rem_est   = 25'(dividend) - ((25'(quot_est) << 8) - 25'(quot_est));
    assign quot      = quot_est + ((rem_est >= 25'd255) ? 17'd1 : 17'd0);
    assign duty_calc = quot[15:0];

    always_comb begin
        track_state = eff_top;
        for (int i = NUM_LEVELS - 2; i >= 0; i--) begin
            if ((3'(i) < eff_top) && (track_lv < r_levels[(i + 1) * 8 +: 8])) begin
                track_state = 3'(i);
            end
        end
    end

    always_comb begin
        n_level   = r_level;
        n_mode    = r_mode;
        n_running = r_running;
        n_out_en  = r_out_en;
        n_supply  = r_supply;
        n_duty    = r_duty;
        n_state   = r_state;
        n_rd_data = 8'd0;
        n_status  = ST_OK;
        do_apply  = 1'b0;

        case (op)
            OP_WR_LEVEL: begin
                if (val > 16'(MAX_LEVEL)) begin
                    n_status = ST_INVALID;
                end else begin
                    do_apply = 1'b1;
                    n_state  = track_state;
                end
            end
            OP_WR_MODE: begin
                if (val > 16'(MODE_AUTO)) begin
                    n_status = ST_INVALID;
                end else if (val[1:0] != r_mode) begin
                    n_mode = val[1:0];
                    if (val[1:0] == MODE_DISABLED) begin
                        if (r_running) begin
                            n_out_en  = 1'b0;
                            n_duty    = 16'd0;
                            n_running = 1'b0;
                            n_level   = 8'd0;
                        end
                        if (r_has_reg) begin
                            n_supply = 1'b0;
                        end
                        n_state = track_state;
                    end else if (!r_running) begin
                        n_duty   = 16'd0;
                        n_out_en = (val[1:0] == MODE_OUTPUT_ON);
                        if (r_has_reg) begin
                            n_supply = (val[1:0] == MODE_SUPPLY_ON) ||
                                       (val[1:0] == MODE_OUTPUT_ON);
                        end
                        n_state = track_state;
                    end
                end
            end
            OP_SET_STATE: begin
                if (val > 16'(eff_top)) begin
                    n_status = ST_INVALID;
                end else if (val[2:0] != r_state) begin
                    do_apply = 1'b1;
                    n_state  = val[2:0];
                end
            end
            OP_RD_LEVEL: n_rd_data = r_level;
            OP_RD_MODE:  n_rd_data = 8'(r_mode);
            OP_RD_STATE: n_rd_data = 8'(r_state);
            OP_RD_TOP:   n_rd_data = 8'(eff_top);
            default:     n_status = ST_UNSUPPORTED;
        endcase

        if (do_apply) begin
            if (apply_lv != 8'd0) begin
                if (r_mode != MODE_DISABLED) begin
                    n_duty  = duty_calc;
                    n_level = apply_lv;
                    if (!r_running) begin
                        if (r_has_reg) begin
                            n_supply = 1'b1;
                        end
                        n_out_en  = 1'b1;
                        n_running = 1'b1;
                    end
                end
            end else begin
                if (r_running) begin
                    n_out_en = 1'b0;
                    n_duty   = 16'd0;
                    if (r_has_reg) begin
                        n_supply = (r_mode == MODE_SUPPLY_ON) || (r_mode == MODE_OUTPUT_ON);
                    end
                    n_running = 1'b0;
                end
                n_level = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= RST_PWM_PERIOD;
            r_levels  <= RST_COOLING_LEVELS;
            r_top     <= RST_TOP_STATE;
            r_has_reg <= RST_HAS_REGULATOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PWM_PERIOD:     r_period  <= i_cfg_data[15:0];
                CFG_COOLING_LEVELS: r_levels  <= i_cfg_data;
                CFG_TOP_STATE:      r_top     <= i_cfg_data[2:0];
                CFG_HAS_REGULATOR:  r_has_reg <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= RST_LEVEL;
            r_mode      <= RST_MODE;
            r_running   <= 1'b1;
            r_out_en    <= 1'b1;
            r_supply    <= RST_HAS_REGULATOR;
            r_duty      <= RST_DUTY;
            r_state     <= RST_STATE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_level     <= n_level;
                r_mode      <= n_mode;
                r_running   <= n_running;
                r_out_en    <= n_out_en;
                r_supply    <= n_supply;
                r_duty      <= n_duty;
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= n_rd_data;
            r_status  <= n_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_rd_data;
    assign o_out.duty_count    = r_duty;
    assign o_out.pwm_output_on = r_out_en;
    assign o_out.supply_on     = r_supply;
    assign o_out.cooling_state = r_state;
    assign o_out.status        = r_status;

endmodule

// File: hdl/pfl_checker.sv
// Port-level checker for the PWM fan level controller and the bind that attaches it.
module pfl_checker
    import pfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_in_opcode,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_read_data,
    input  logic [15:0] i_out_duty_count,
    input  logic [2:0]  i_out_cooling_state,
    input  logic [1:0]  i_out_status
);

    logic in_fire;
    assign in_fire = i_in_valid && i_in_ready;

    // An accepted request always yields a result beat on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> i_out_valid)
        else $error("accepted request did not produce a result");

    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_opcode == OP_UNSUPPORTED) |=>
            (i_out_status == ST_UNSUPPORTED) && (i_out_read_data == 8'd0))
        else $error("unsupported request answered wrongly");

    a_read_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_opcode == OP_RD_TOP) |=>
            (i_out_status == ST_OK) && (i_out_read_data <= 8'(MAX_STATE)))
        else $error("top state read back out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_read_data) && $stable(i_out_duty_count) &&
            $stable(i_out_cooling_state) && $stable(i_out_status))
        else $error("stalled result beat changed");

endmodule

bind pwm_fan_level_controller_top pfl_checker u_pfl_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_in_opcode         (i_in.opcode),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_read_data     (o_out.read_data),
    .i_out_duty_count    (o_out.duty_count),
    .i_out_cooling_state (o_out.cooling_state),
    .i_out_status        (o_out.status)
);

// File: dv/pwm_fan_level_controller_top_test.sv
// Self-checking testbench for the PWM fan level controller with directed and random request traffic.
`timescale 1ns / 1ps

module pwm_fan_level_controller_top_test;
    import pfl_pkg::*;

    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_DIRECTED = 25;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0]  read_data;
        logic [15:0] duty_count;
        logic        pwm_output_on;
        logic        supply_on;
        logic [2:0]  cooling_state;
        logic [1:0]  status;
    } t_fan_report;

    class fan_scoreboard;
        logic [15:0] period;
        logic [63:0] levels;
        logic [2:0]  top;
        logic        has_reg;
        logic [7:0]  level;
        t_mode       mode;
        bit          running;
        bit          out_en;
        bit          supply_en;
        logic [15:0] duty;
        logic [2:0]  state;
        t_fan_report reports_due[$];
        int          errors;

        function new();
            period    = RST_PWM_PERIOD;
            levels    = RST_COOLING_LEVELS;
            top       = RST_TOP_STATE;
            has_reg   = RST_HAS_REGULATOR;
            level     = RST_LEVEL;
            mode      = RST_MODE;
            running   = 1'b1;
            out_en    = 1'b1;
            supply_en = RST_HAS_REGULATOR;
            duty      = RST_DUTY;
            state     = eff_top();
            errors    = 0;
        endfunction

        function logic [2:0] eff_top();
            return (top > MAX_STATE) ? MAX_STATE : top;
        endfunction

        function logic [7:0] level_at(input int unsigned idx);
            return levels[(idx % 8) * 8 +: 8];
        endfunction

        function void set_supply(input bit on);
            if (has_reg) begin
                supply_en = on;
            end
        endfunction

        function void apply_level(input logic [7:0] lv);
            int unsigned span;
            span = (period == 16'd0) ? 0 : period - 16'd1;
            if (lv != 8'd0) begin
                if (mode == MODE_DISABLED) begin
                    return;
                end
                duty = 16'((int'(lv) * span + 254) / 255);
                if (!running) begin
                    set_supply(1'b1);
                    out_en  = 1'b1;
                    running = 1'b1;
                end
            end else if (running) begin
                out_en = 1'b0;
                duty   = 16'd0;
                set_supply(mode == MODE_SUPPLY_ON || mode == MODE_OUTPUT_ON);
                running = 1'b0;
            end
            level = lv;
        endfunction

        function void track_state(input logic [7:0] lv);
            int unsigned idx;
            idx = 0;
            while (idx < eff_top() && lv >= level_at(idx + 1)) begin
                idx++;
            end
            state = 3'(idx);
        endfunction

        function void write_mode(input t_mode m);
            if (mode == m) begin
                return;
            end
            mode = m;
            if (m == MODE_DISABLED) begin
                if (running) begin
                    apply_level(8'd0);
                end else begin
                    set_supply(1'b0);
                end
            end else if (!running) begin
                duty   = 16'd0;
                out_en = (m == MODE_OUTPUT_ON);
                set_supply(m == MODE_SUPPLY_ON || m == MODE_OUTPUT_ON);
            end else begin
                return;
            end
            track_state(8'd0);
        endfunction

        function void write_reg(input t_cfg_index idx, input logic [63:0] data);
            case (idx)
                CFG_PWM_PERIOD: period = data[15:0];
                CFG_COOLING_LEVELS: levels = data;
                CFG_TOP_STATE: top = data[2:0];
                default: has_reg = data[0];
            endcase
        endfunction

        function void note_access(input t_opcode op, input logic [15:0] val);
            t_fan_report rep;
            rep.read_data = 8'd0;
            rep.status = ST_OK;
            case (op)
                OP_WR_LEVEL: begin
                    if (val > 16'd255) begin
                        rep.status = ST_INVALID;
                    end else begin
                        apply_level(val[7:0]);
                        track_state(val[7:0]);
                    end
                end
                OP_WR_MODE: begin
                    if (val > 16'd3) begin
                        rep.status = ST_INVALID;
                    end else begin
                        write_mode(t_mode'(val[1:0]));
                    end
                end
                OP_SET_STATE: begin
                    if (val > 16'(eff_top())) begin
                        rep.status = ST_INVALID;
                    end else if (val[2:0] != state) begin
                        apply_level(level_at(val));
                        state = val[2:0];
                    end
                end
                OP_RD_LEVEL: rep.read_data = level;
                OP_RD_MODE: rep.read_data = 8'(mode);
                OP_RD_STATE: rep.read_data = 8'(state);
                OP_RD_TOP: rep.read_data = 8'(eff_top());
                default: rep.status = ST_UNSUPPORTED;
            endcase
            rep.duty_count    = duty;
            rep.pwm_output_on = out_en;
            rep.supply_on     = supply_en;
            rep.cooling_state = state;
            reports_due.push_back(rep);
        endfunction

        function void check_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(input t_fan_report got);
            t_fan_report want;
            if (reports_due.size() == 0) begin
                $error("result beat arrived with no request outstanding");
                errors++;
                return;
            end
            want = reports_due.pop_front();
            check_field("read_data", 16'(want.read_data), 16'(got.read_data));
            check_field("duty_count", want.duty_count, got.duty_count);
            check_field("pwm_output_on", 16'(want.pwm_output_on), 16'(got.pwm_output_on));
            check_field("supply_on", 16'(want.supply_on), 16'(got.supply_on));
            check_field("cooling_state", 16'(want.cooling_state), 16'(got.cooling_state));
            check_field("status", 16'(want.status), 16'(got.status));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [63:0] i_cfg_data;
    int          cycles = 0;

    pfl_in_if  in_if();
    pfl_out_if out_if();

    fan_scoreboard sb = new();

    t_opcode dir_op[NUM_DIRECTED] = '{
        OP_RD_LEVEL, OP_RD_MODE, OP_RD_STATE, OP_RD_TOP, OP_UNSUPPORTED,
        OP_WR_LEVEL, OP_WR_LEVEL, OP_WR_LEVEL, OP_WR_LEVEL, OP_WR_LEVEL,
        OP_WR_MODE, OP_WR_MODE, OP_WR_MODE, OP_WR_LEVEL, OP_WR_MODE,
        OP_WR_MODE, OP_WR_MODE, OP_SET_STATE, OP_SET_STATE, OP_SET_STATE,
        OP_SET_STATE, OP_SET_STATE, OP_WR_LEVEL, OP_RD_STATE, OP_SET_STATE
    };
    logic [15:0] dir_val[NUM_DIRECTED] = '{
        16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF,
        16'd256, 16'hFFFF, 16'd0, 16'd255, 16'd1,
        16'd4, 16'hFFFF, 16'd0, 16'd100, 16'd2,
        16'd3, 16'd1, 16'd4, 16'd4, 16'd5,
        16'hFFFF, 16'd0, 16'h0066, 16'h0000, 16'd2
    };

    pwm_fan_level_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_fan_report got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_access(in_if.opcode, in_if.value);
            end
            if (out_if.valid && out_if.ready) begin
                got.read_data     = out_if.read_data;
                got.duty_count    = out_if.duty_count;
                got.pwm_output_on = out_if.pwm_output_on;
                got.supply_on     = out_if.supply_on;
                got.cooling_state = out_if.cooling_state;
                got.status        = out_if.status;
                sb.check_report(got);
            end
        end
    end

    // The receiver switches between stall styles for stretches of random length.
    initial begin
        int hold;
        int style;
        hold = 0;
        style = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                style = $urandom_range(0, 3);
                hold = $urandom_range(16, 200);
            end
            hold--;
            case (style)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 3) != 0);
                2: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= hold[2];
            endcase
        end
    end

    task automatic send_beat(input t_opcode op, input logic [15:0] val);
        in_if.valid  <= 1'b1;
        in_if.opcode <= op;
        in_if.value  <= val;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic pick_access(output t_opcode op, output logic [15:0] val);
        int r;
        int k;
        int lv;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        val = 16'($urandom_range(0, 16'hFFFF));
        if (r < 35) begin
            op = OP_WR_LEVEL;
            if (k == 0) begin
                val = 16'd0;
            end else if (k == 1) begin
                val = 16'd255;
            end else if (k < 4) begin
                lv = int'(sb.level_at($urandom_range(0, 7))) + $urandom_range(0, 2) - 1;
                val = 16'((lv < 0) ? 0 : (lv > 255) ? 255 : lv);
            end else if (k > 4) begin
                val = 16'($urandom_range(0, 255));
            end
        end else if (r < 55) begin
            op = OP_SET_STATE;
            if (k == 1) begin
                val = 16'($urandom_range(0, 7));
            end else if (k > 1) begin
                val = 16'($urandom_range(0, sb.eff_top()));
            end
        end else if (r < 67) begin
            op = OP_WR_MODE;
            if (k != 0) begin
                val = 16'($urandom_range(0, 3));
            end
        end else if (r < 95) begin
            op = t_opcode'($urandom_range(OP_RD_LEVEL, OP_RD_TOP));
        end else begin
            op = OP_UNSUPPORTED;
        end
    endtask

    task automatic run_items(input int count, input bit directed);
        int burst;
        int gap;
        int idx;
        t_opcode op;
        logic [15:0] val;
        burst = 0;
        for (idx = 0; idx < count; idx++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (directed) begin
                op = dir_op[idx];
                val = dir_val[idx];
            end else begin
                pick_access(op, val);
            end
            send_beat(op, val);
            burst--;
        end
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (sb.reports_due.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input int phase);
        logic [63:0] lvls;
        int lv;
        int idx;
        case (phase)
            0: begin
                write_cfg(CFG_PWM_PERIOD, 64'd0);
                write_cfg(CFG_COOLING_LEVELS, 64'd0);
                write_cfg(CFG_TOP_STATE, 64'd0);
                write_cfg(CFG_HAS_REGULATOR, 64'd0);
            end
            1: begin
                write_cfg(CFG_PWM_PERIOD, 64'd65535);
                write_cfg(CFG_COOLING_LEVELS, {64{1'b1}});
                write_cfg(CFG_TOP_STATE, 64'(MAX_STATE));
                write_cfg(CFG_HAS_REGULATOR, 64'd1);
            end
            2: begin
                write_cfg(CFG_PWM_PERIOD, 64'd1);
                write_cfg(CFG_COOLING_LEVELS, RST_COOLING_LEVELS);
                write_cfg(CFG_TOP_STATE, 64'(MAX_STATE));
                write_cfg(CFG_HAS_REGULATOR, 64'd1);
            end
            default: begin
                if (phase % 2 == 0) begin
                    lvls = {$urandom, $urandom};
                end else begin
                    lv = 0;
                    for (idx = 0; idx < NUM_LEVELS; idx++) begin
                        lvls[idx * 8 +: 8] = 8'(lv);
                        lv = lv + $urandom_range(0, (255 - lv) / 3 + 1);
                        if (lv > 255) begin
                            lv = 255;
                        end
                    end
                end
                write_cfg(CFG_PWM_PERIOD, 64'($urandom_range(0, 16'hFFFF)));
                write_cfg(CFG_COOLING_LEVELS, lvls);
                write_cfg(CFG_TOP_STATE, 64'($urandom_range(0, 7)));
                write_cfg(CFG_HAS_REGULATOR, 64'($urandom_range(0, 1)));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int phase;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_PWM_PERIOD;
        i_cfg_data   <= 64'd0;
        in_if.valid  <= 1'b0;
        in_if.opcode <= OP_RD_LEVEL;
        in_if.value  <= 16'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_items(NUM_DIRECTED, 1'b1);
        wait_idle();
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            configure(phase);
            run_items(PHASE_ITEMS, 1'b0);
            wait_idle();
        end
        if (sb.errors == 0 && sb.reports_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
